// ===== src/lgl_pkg.sv =====
// shared types, constants and helpers for the life generation line engine
// no dependencies; every other file imports this package
`default_nettype none

package lgl_pkg;

    localparam int LINE_CELLS = 64;
    localparam int LEN_W      = 7;
    localparam int CNT_W      = 4;

    // b3/s23 neighbour counts
    localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SURVIVE_LOW   = CNT_W'(2);
    localparam logic [CNT_W-1:0] SURVIVE_LIMIT = CNT_W'(4);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

    typedef logic [LINE_CELLS-1:0] line_t;

    // 3x3 window around one cell
    typedef struct packed {
        logic [2:0] up;
        logic       left;
        logic       centre;
        logic       right;
        logic [2:0] down;
    } nbhd_t;

    typedef struct packed {
        line_t next_cells;
        line_t born_mask;
        line_t died_mask;
        logic  generation_done;
    } result_t;

    // lanes below the length are in use; lengths beyond the line saturate
    function automatic line_t lane_mask(input logic [LEN_W-1:0] len);
        line_t m;
        for (int i = 0; i < LINE_CELLS; i++)
        begin
            m[i] = (int'(len) > i);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/lgl_ifs.sv =====
// handshake channels of the life generation line engine: line in, result out, config
// depends on lgl_pkg
`default_nettype none

interface lgl_line_if;
    import lgl_pkg::*;
    logic  valid;
    logic  ready;
    line_t cells;
    logic  final_line;
    modport source (output valid, output cells, output final_line, input ready);
    modport sink   (input valid, input cells, input final_line, output ready);
endinterface

interface lgl_result_if;
    import lgl_pkg::*;
    logic  valid;
    logic  ready;
    line_t next_cells;
    line_t born_mask;
    line_t died_mask;
    logic  generation_done;
    modport source (output valid, output next_cells, output born_mask, output died_mask,
                    output generation_done, input ready);
    modport sink   (input valid, input next_cells, input born_mask, input died_mask,
                    input generation_done, output ready);
endinterface

interface lgl_cfg_if;
    import lgl_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] line_length;
    modport source (output valid, output line_length, input ready);
    modport sink   (input valid, input line_length, output ready);
endinterface

`default_nettype wire

// ===== src/lgl_lane.sv =====
// one cell lane: neighbour count and the b3/s23 rule
// depends on lgl_pkg
`default_nettype none

module lgl_lane (
    input  var lgl_pkg::nbhd_t hood,
    output logic               lives
);
    import lgl_pkg::*;

    logic [CNT_W-1:0] cnt;

    assign cnt = CNT_W'($countones({hood.up, hood.left, hood.right, hood.down}));

    always_comb
    begin
        if (hood.centre)
            lives = (cnt >= SURVIVE_LOW) && (cnt < SURVIVE_LIMIT);
        else
            lives = (cnt == BIRTH_COUNT);
    end

endmodule

`default_nettype wire

// ===== src/lgl_row.sv =====
// row of cell lanes plus the merge that masks lanes and forms born and died masks
// depends on lgl_pkg and lgl_lane
`default_nettype none

module lgl_row (
    input  var lgl_pkg::line_t   up,
    input  var lgl_pkg::line_t   mid,
    input  var lgl_pkg::line_t   down,
    input  var lgl_pkg::line_t   mask,
    input  logic                 done,
    output lgl_pkg::result_t     res
);
    import lgl_pkg::*;

    line_t up_m;
    line_t mid_m;
    line_t down_m;
    line_t lives;
    line_t nxt;

    assign up_m   = up & mask;
    assign mid_m  = mid & mask;
    assign down_m = down & mask;

    for (genvar i = 0; i < LINE_CELLS; i++)
    begin : g_lane
        nbhd_t hood;

        // cells beyond either end of the line are dead
        if (i == 0)
        begin : g_first
            assign hood.up[0]   = 1'b0;
            assign hood.left    = 1'b0;
            assign hood.down[0] = 1'b0;
        end
        else
        begin : g_inner_l
            assign hood.up[0]   = up_m[i-1];
            assign hood.left    = mid_m[i-1];
            assign hood.down[0] = down_m[i-1];
        end

        if (i == LINE_CELLS-1)
        begin : g_last
            assign hood.up[2]   = 1'b0;
            assign hood.right   = 1'b0;
            assign hood.down[2] = 1'b0;
        end
        else
        begin : g_inner_r
            assign hood.up[2]   = up_m[i+1];
            assign hood.right   = mid_m[i+1];
            assign hood.down[2] = down_m[i+1];
        end

        assign hood.up[1]   = up_m[i];
        assign hood.centre  = mid_m[i];
        assign hood.down[1] = down_m[i];

        lgl_lane u_lane (
            .hood  (hood),
            .lives (lives[i])
        );
    end

    assign nxt = lives & mask;

    assign res.next_cells      = nxt;
    assign res.born_mask       = nxt & ~mid_m;
    assign res.died_mask       = mid_m & ~nxt;
    assign res.generation_done = done;

endmodule

`default_nettype wire

// ===== src/life_generation_line_engine.sv =====
// life generation line engine top: line window, two lane rows, output buffer
// depends on lgl_pkg, lgl_ifs, lgl_row
// a result is registered into the output buffer on the beat that causes it and is offered in order
// line beats are taken one per cycle while at most one result waits in the buffer; a final line
// yields two result beats when a line is held (one when none is), which can hold off the next line
// reset: line window cleared (all dead), no lines held, buffer empty, line_length 32
`default_nettype none

module life_generation_line_engine (
    input  logic           clk,
    input  logic           rst_n,
    lgl_line_if.sink       line_in,
    lgl_result_if.source   result_out,
    lgl_cfg_if.sink        cfg
);
    import lgl_pkg::*;

    localparam int BUF_DEPTH = 3;
    localparam int PTR_W     = 2;
    localparam int CNT_BW    = 2;

    // lane mask, kept decoded from the written length
    line_t mask_reg;
    line_t mask_next;

    // line window: the line above the held one and the held one
    line_t above_reg;
    line_t above_next;
    line_t middle_reg;
    line_t middle_next;
    logic  seen_reg;
    logic  seen_next;

    // output buffer, three entries so a two-result beat fits behind one waiting beat
    result_t            buf_reg [BUF_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_BW-1:0]  count_reg;
    logic [CNT_BW-1:0]  count_next;

    logic    in_fire;
    logic    out_fire;
    logic    push_a;
    logic    push_b;
    line_t   cur;
    result_t res_a;
    result_t res_b;
    logic [PTR_W-1:0] slot_b;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUF_DEPTH-1)) ? '0 : p + PTR_W'(1);
    endfunction

    // config: always ready; the user must write it only while idle, the block does not enforce this
    assign cfg.ready = 1'b1;
    assign mask_next = (cfg.valid) ? lane_mask(cfg.line_length) : mask_reg;

    // handshakes
    assign line_in.ready    = (count_reg <= CNT_BW'(1));
    assign in_fire          = line_in.valid & line_in.ready;
    assign result_out.valid = (count_reg != '0);
    assign out_fire         = result_out.valid & result_out.ready;

    assign cur = line_in.cells & mask_reg;

    // result for the held line, once its line below has arrived
    assign push_a = in_fire & seen_reg;
    // result for the final line itself, line below dead
    assign push_b = in_fire & line_in.final_line;

    lgl_row u_row_held (
        .up   (above_reg),
        .mid  (middle_reg),
        .down (cur),
        .mask (mask_reg),
        .done (1'b0),
        .res  (res_a)
    );

    // middle_reg is all dead when no line is held, so a lone line sees dead neighbours
    lgl_row u_row_final (
        .up   (middle_reg),
        .mid  (cur),
        .down ('0),
        .mask (mask_reg),
        .done (1'b1),
        .res  (res_b)
    );

    // window update
    always_comb
    begin
        above_next  = above_reg;
        middle_next = middle_reg;
        seen_next   = seen_reg;
        if (in_fire)
        begin
            if (line_in.final_line)
            begin
                above_next  = '0;
                middle_next = '0;
                seen_next   = 1'b0;
            end
            else
            begin
                above_next  = middle_reg;
                middle_next = cur;
                seen_next   = 1'b1;
            end
        end
    end

    // buffer pointers and fill count
    always_comb
    begin
        slot_b      = push_a ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (push_b)
            wr_ptr_next = ptr_inc(slot_b);
        else if (push_a)
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        rd_ptr_next = out_fire ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CNT_BW'({1'b0, count_reg} + {2'b0, push_a} + {2'b0, push_b}
                              - {2'b0, out_fire});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= lane_mask(LEN_RESET);
            above_reg  <= '0;
            middle_reg <= '0;
            seen_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mask_reg   <= mask_next;
            above_reg  <= above_next;
            middle_reg <= middle_next;
            seen_reg   <= seen_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_a)
            buf_reg[wr_ptr_reg] <= res_a;
        if (push_b)
            buf_reg[slot_b] <= res_b;
    end

    assign result_out.next_cells      = buf_reg[rd_ptr_reg].next_cells;
    assign result_out.born_mask       = buf_reg[rd_ptr_reg].born_mask;
    assign result_out.died_mask       = buf_reg[rd_ptr_reg].died_mask;
    assign result_out.generation_done = buf_reg[rd_ptr_reg].generation_done;

endmodule

`default_nettype wire

// ===== test/life_generation_line_engine_test.sv =====
// self-checking bench for the life generation line engine: grids of random lines
// are checked against a b3/s23 line predictor; depends on lgl_pkg, lgl_ifs and the rtl top
`timescale 1ns / 100ps

module life_generation_line_engine_test;
    import lgl_pkg::*;

    // predicts one generation line by line and holds the results still owed by the block
    class generation_board;
        logic [LEN_W-1:0] length_now;
        line_t            line_up;
        line_t            line_held;
        int               lines_held;
        result_t          awaited_results[$];
        int               faults;

        function new();
            length_now = LEN_RESET;
            line_up    = '0;
            line_held  = '0;
            lines_held = 0;
            faults     = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            length_now = len;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // lanes below the length are live, lengths past the line saturate
        function line_t live_lanes();
            line_t m;
            for (int i = 0; i < LINE_CELLS; i++)
            begin
                m[i] = (int'(length_now) > i);
            end
            return m;
        endfunction

        function line_t next_generation(line_t up, line_t mid, line_t dn, line_t m);
            line_t res;
            int    cnt;
            res = '0;
            for (int i = 0; i < LINE_CELLS; i++)
            begin
                cnt = 0;
                for (int d = -1; d <= 1; d++)
                begin
                    if (i + d >= 0 && i + d < LINE_CELLS)
                    begin
                        cnt += int'(up[i+d]) + int'(dn[i+d]);
                        if (d != 0)
                            cnt += int'(mid[i+d]);
                    end
                end
                if (mid[i])
                    res[i] = (cnt >= int'(SURVIVE_LOW)) && (cnt < int'(SURVIVE_LIMIT));
                else
                    res[i] = (cnt == int'(BIRTH_COUNT));
            end
            return res & m;
        endfunction

        function void owe_line(line_t up, line_t mid, line_t dn, line_t m, logic done);
            result_t r;
            line_t   old;
            old               = mid & m;
            r.next_cells      = next_generation(up & m, old, dn & m, m);
            r.born_mask       = r.next_cells & ~old;
            r.died_mask       = old & ~r.next_cells;
            r.generation_done = done;
            awaited_results.push_back(r);
        endfunction

        // one accepted line beat
        function void take_line(line_t cells, logic fin);
            line_t m;
            line_t cur;
            m   = live_lanes();
            cur = cells & m;
            if (lines_held == 0)
            begin
                if (fin)
                    owe_line('0, cur, '0, m, 1'b1);
                else
                begin
                    line_up    = '0;
                    line_held  = cur;
                    lines_held = 1;
                end
            end
            else
            begin
                owe_line(line_up, line_held, cur, m, 1'b0);
                line_up    = line_held;
                line_held  = cur;
                lines_held = 2;
                if (fin)
                begin
                    owe_line(line_up, line_held, '0, m, 1'b1);
                    line_up    = '0;
                    line_held  = '0;
                    lines_held = 0;
                end
            end
        endfunction

        // one accepted result beat against the oldest owed result
        function void check_result(result_t got);
            result_t exp;
            if (awaited_results.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected result, expected none, actual %h %h %h %b", $time,
                         got.next_cells, got.born_mask, got.died_mask, got.generation_done);
                return;
            end
            exp = awaited_results.pop_front();
            if (got.next_cells !== exp.next_cells)
            begin
                faults++;
                $display("%0t: next_cells expected %h, actual %h", $time,
                         exp.next_cells, got.next_cells);
            end
            if (got.born_mask !== exp.born_mask)
            begin
                faults++;
                $display("%0t: born_mask expected %h, actual %h", $time,
                         exp.born_mask, got.born_mask);
            end
            if (got.died_mask !== exp.died_mask)
            begin
                faults++;
                $display("%0t: died_mask expected %h, actual %h", $time,
                         exp.died_mask, got.died_mask);
            end
            if (got.generation_done !== exp.generation_done)
            begin
                faults++;
                $display("%0t: generation_done expected %b, actual %b", $time,
                         exp.generation_done, got.generation_done);
            end
        endfunction
    endclass

    localparam line_t ALL_LIVE = '1;

    logic clk;
    logic rst_n;
    // when set, neither side idles: back-to-back beats
    logic calm;

    generation_board board;

    lgl_line_if   line_if();
    lgl_result_if res_if();
    lgl_cfg_if    cfg_if();

    life_generation_line_engine u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (line_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle cycles before a beat, none during a calm stretch
    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // mix of dense, sparse and very sparse lines so that patterns evolve
    function automatic line_t random_cells();
        line_t a;
        line_t b;
        line_t c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return a;
            1: return a & b;
            2: return a & b & c;
            default: return a | b;
        endcase
    endfunction

    // mostly real lengths, now and then zero, the full line or beyond it
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? LEN_W'(0) : LEN_W'(127);
            1: return LEN_W'($urandom_range(65, 126));
            2, 3: return LEN_W'(LINE_CELLS);
            default: return LEN_W'($urandom_range(1, 64));
        endcase
    endfunction

    // all line tasks start and end at a falling edge
    task automatic send_line(line_t cells, logic fin);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            line_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        line_if.valid      = 1'b1;
        line_if.cells      = cells;
        line_if.final_line = fin;
        do
            @(posedge clk);
        while (!line_if.ready);
        board.take_line(cells, fin);
        @(negedge clk);
    endtask

    // drop valid, let owed results drain, then allow for a line still being held
    task automatic wait_idle();
        line_if.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        cfg_if.valid       = 1'b1;
        cfg_if.line_length = len;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        board.set_length(len);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // result side: random stall per beat, every accepted beat is checked
    initial
    begin
        int      stall;
        result_t got;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = draw_gap();
            if (stall > 0)
            begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready = 1'b1;
            do
                @(posedge clk);
            while (res_if.valid !== 1'b1);
            got.next_cells      = res_if.next_cells;
            got.born_mask       = res_if.born_mask;
            got.died_mask       = res_if.died_mask;
            got.generation_done = res_if.generation_done;
            board.check_result(got);
        end
    end

    // main stimulus
    initial
    begin
        int sent;
        int rows;
        board              = new();
        calm               = 1'b0;
        rst_n              = 1'b0;
        line_if.valid      = 1'b0;
        line_if.cells      = '0;
        line_if.final_line = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.line_length = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single-line grid at the reset length: all lanes from 32 up must read dead
        send_line(ALL_LIVE, 1'b1);

        // blinker in a three-line grid
        send_line('0, 1'b0);
        send_line(line_t'(64'h70), 1'b0);
        send_line('0, 1'b1);

        // full line: corner cells and a solid grid to exercise both line ends
        wait_idle();
        write_length(LEN_W'(LINE_CELLS));
        send_line(line_t'(64'h8000_0000_0000_0001), 1'b0);
        send_line(line_t'(64'hC000_0000_0000_0003), 1'b0);
        send_line(line_t'(64'h8000_0000_0000_0001), 1'b1);
        send_line(ALL_LIVE, 1'b0);
        send_line(ALL_LIVE, 1'b1);

        // length of zero: nothing is in use
        wait_idle();
        write_length(LEN_W'(0));
        send_line(ALL_LIVE, 1'b0);
        send_line(random_cells(), 1'b1);

        // largest length saturates at the full line
        wait_idle();
        write_length(LEN_W'(127));
        send_line(random_cells(), 1'b0);
        send_line(ALL_LIVE, 1'b1);

        // one lane only
        wait_idle();
        write_length(LEN_W'(1));
        send_line(ALL_LIVE, 1'b0);
        send_line(ALL_LIVE, 1'b0);
        send_line(ALL_LIVE, 1'b1);

        // length shrinks while two lines are held
        wait_idle();
        write_length(LEN_W'(LINE_CELLS));
        send_line(ALL_LIVE, 1'b0);
        send_line(random_cells(), 1'b0);
        wait_idle();
        write_length(LEN_W'(8));
        send_line(ALL_LIVE, 1'b1);

        // random grids, mostly a few lines tall, now and then a new length
        sent = 0;
        while (sent < 800)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_length(pick_length());
            end
            calm = ($urandom_range(0, 4) == 0);
            rows = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
            for (int r = 0; r < rows; r++)
            begin
                // rare change of length in the middle of a grid
                if (r > 0 && $urandom_range(0, 39) == 0)
                begin
                    wait_idle();
                    write_length(pick_length());
                end
                send_line(random_cells(), r == rows - 1);
                sent++;
            end
        end

        calm          = 1'b0;
        line_if.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        // wait on so that a stray result would still be caught
        repeat (10) @(negedge clk);
        if (board.faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
